[rtl/rfhp_pkg.sv]
// Shared types and constants for the receive fabric header parser.
// No dependencies; used by every module of the block by scoped names.
package rfhp_pkg;

  localparam int unsigned IDX_W     = 14;
  localparam int unsigned HLEN_W    = 6;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [IDX_W-1:0]  IDX_MAX    = {IDX_W{1'b1}};
  localparam logic [HLEN_W-1:0] FIXED_HDR  = 6'd18;
  localparam logic [HLEN_W-1:0] CRC_KEEP   = 6'd2;
  // last byte at index below this leaves fewer than the minimum frame bytes
  localparam logic [IDX_W-1:0]  SHORT_LAST = 14'd15;

  // header byte positions
  localparam logic [IDX_W-1:0]  POS_SIZE_HI = 14'd0;
  localparam logic [IDX_W-1:0]  POS_SIZE_LO = 14'd1;
  localparam logic [IDX_W-1:0]  POS_PORT_HI = 14'd2;
  localparam logic [IDX_W-1:0]  POS_PORT_MD = 14'd3;
  localparam logic [IDX_W-1:0]  POS_PORT_LO = 14'd4;
  localparam logic [IDX_W-1:0]  POS_SYS_HDR = 14'd9;

  typedef enum logic [1:0] {
    ST_OK              = 2'd0,
    ST_TOO_SMALL       = 2'd1,
    ST_SIZE_MISMATCH   = 2'd2,
    ST_FRAMER_DISABLED = 2'd3
  } status_e;

  // one request handed from the parser to the result stage
  typedef struct packed {
    logic [7:0]        data;
    logic              pass;
    logic              last;
    logic              enable;
    logic              short_frame;
    logic [IDX_W-1:0]  size;
    logic [HLEN_W-1:0] hlen;
    logic [IDX_W-1:0]  pcount;
    logic [15:0]       port;
    logic [7:0]        trap;
    logic              trap_present;
  } entry_t;

  // frame byte position of the trap code for each ext4 code
  function automatic logic [4:0] trap_pos(input logic [1:0] ext4);
    logic [4:0] pos;
    unique case (ext4)
      2'd1:    pos = 5'd18;
      2'd2:    pos = 5'd20;
      2'd3:    pos = 5'd23;
      default: pos = 5'd0;
    endcase
    return pos;
  endfunction

  // header length from the first system-header byte
  function automatic logic [HLEN_W-1:0] hdr_len(input logic [7:0] b);
    logic [HLEN_W-1:0] len;
    len = FIXED_HDR;
    unique case (b[5:4])
      2'd1:    len = len + 6'd3;
      2'd2:    len = len + 6'd5;
      2'd3:    len = len + 6'd8;
      default: len = len;
    endcase
    if (b[7]) len = len + 6'd3;
    if (b[6]) len = len + 6'd5;
    return len;
  endfunction

endpackage

[rtl/rx_fabric_header_parser.sv]
// Top level of the receive fabric header parser: enable register, parser
// front end, request queue and result stage. Depends on rfhp_pkg and all rfhp_* modules.
//
//   channel   | handshake           | payload
//   ----------+---------------------+-----------------------------------------
//   input     | push / full         | frame_byte_i, frame_last_i
//   result    | empty / pop         | payload_byte_o .. trap_present_o
//   config    | framer_enable_we_i  | framer_enable_wdata_i
//
// One byte is accepted per cycle while the queue is not full; its request is
// written into the queue at the accepting edge and moves on to the result slot
// when that slot is free. Bytes that produce no result never enter the 4-deep
// queue. full follows the queue, so input stalls only when the queue is full;
// the result slot reloads in the cycle it is popped.
// Reset clears frame state, queue and result slot; the enable resets to 0.
module rx_fabric_header_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              framer_enable_we_i,
  input  logic              framer_enable_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        frame_byte_i,
  input  logic              frame_last_i,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        payload_byte_o,
  output logic              has_byte_o,
  output logic              end_of_frame_o,
  output logic [1:0]        frame_status_o,
  output logic [15:0]       system_port_o,
  output logic [7:0]        trap_value_o,
  output logic              trap_present_o
);

  logic              enable_q;
  logic              accept;
  logic              req_valid;
  rfhp_pkg::entry_t  req, q_head;
  logic              q_full, q_avail, q_take;
  rfhp_pkg::status_e status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (framer_enable_we_i) begin
      enable_q <= framer_enable_wdata_i;
    end
  end

  assign full   = q_full;
  assign accept = push && !q_full;

  rfhp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .accept_i    (accept),
    .byte_i      (frame_byte_i),
    .last_i      (frame_last_i),
    .req_valid_o (req_valid),
    .req_o       (req)
  );

  rfhp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (req_valid),
    .wr_data_i (req),
    .full_o    (q_full),
    .avail_o   (q_avail),
    .rd_i      (q_take),
    .rd_data_o (q_head)
  );

  rfhp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .avail_i        (q_avail),
    .req_i          (q_head),
    .take_o         (q_take),
    .empty_o        (empty),
    .pop_i          (pop),
    .payload_byte_o (payload_byte_o),
    .has_byte_o     (has_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .frame_status_o (status),
    .system_port_o  (system_port_o),
    .trap_value_o   (trap_value_o),
    .trap_present_o (trap_present_o)
  );

  assign frame_status_o = status;

  // a result without a byte must close a frame
  a_nobyte_is_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !has_byte_o |-> end_of_frame_o)
    else $error("result without byte and without end of frame");

  // a passed byte implies the framer was enabled
  a_byte_not_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && has_byte_o |-> status != rfhp_pkg::ST_FRAMER_DISABLED)
    else $error("passed byte carries framer disabled status");

  // mid-frame results carry no status
  a_midframe_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !end_of_frame_o |-> status == rfhp_pkg::ST_OK)
    else $error("status set on a mid-frame result");

  // queue is never written while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !req_valid)
    else $error("request written into a full queue");

endmodule

[rtl/rfhp_front.sv]
// Parser front end: byte counter, header field capture, pass decision.
// Depends on rfhp_pkg; feeds requests into rfhp_queue.
module rfhp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             enable_i,
  input  logic             accept_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output logic             req_valid_o,
  output rfhp_pkg::entry_t req_o
);

  logic [rfhp_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [rfhp_pkg::IDX_W-1:0]  size_q, size_d;
  logic [15:0]                 port_q, port_d;
  logic [3:0]                  ext_q, ext_d;
  logic [rfhp_pkg::HLEN_W-1:0] hlen_q, hlen_d;
  logic [7:0]                  trap_q, trap_d;
  logic [rfhp_pkg::IDX_W-1:0]  pcnt_q, pcnt_d;
  logic                        hit;
  logic                        pass;
  logic [rfhp_pkg::HLEN_W-1:0] strip_len;

  always_comb begin
    size_d = size_q;
    port_d = port_q;
    ext_d  = ext_q;
    hlen_d = hlen_q;
    trap_d = trap_q;
    unique case (idx_q)
      rfhp_pkg::POS_SIZE_HI: size_d = {byte_i, size_q[5:0]};
      rfhp_pkg::POS_SIZE_LO: size_d = {size_q[13:6], byte_i[7:2]};
      rfhp_pkg::POS_PORT_HI: port_d = {byte_i[6:0], port_q[8:0]};
      rfhp_pkg::POS_PORT_MD: port_d = {port_q[15:9], byte_i, port_q[0]};
      rfhp_pkg::POS_PORT_LO: port_d = {port_q[15:1], byte_i[7]};
      rfhp_pkg::POS_SYS_HDR: begin
        ext_d  = byte_i[7:4];
        hlen_d = rfhp_pkg::hdr_len(byte_i);
      end
      default: ;
    endcase
    // trap positions all lie past the system header byte, so ext_q is settled
    if (ext_q[1:0] != 2'd0 &&
        idx_q == {{(rfhp_pkg::IDX_W-5){1'b0}}, rfhp_pkg::trap_pos(ext_q[1:0])}) begin
      trap_d = byte_i;
    end
  end

  // header length can only change at index 9, well before any byte passes
  assign strip_len = hlen_q - rfhp_pkg::CRC_KEEP;
  assign hit       = idx_q >= {{(rfhp_pkg::IDX_W-rfhp_pkg::HLEN_W){1'b0}}, strip_len};
  assign pass      = hit && enable_i;
  assign pcnt_d    = (hit && pcnt_q != rfhp_pkg::IDX_MAX) ? pcnt_q + 1'b1 : pcnt_q;
  assign idx_d     = (idx_q != rfhp_pkg::IDX_MAX) ? idx_q + 1'b1 : idx_q;

  assign req_valid_o = accept_i && (pass || last_i);

  always_comb begin
    req_o.data         = byte_i;
    req_o.pass         = pass;
    req_o.last         = last_i;
    req_o.enable       = enable_i;
    req_o.short_frame  = idx_q < rfhp_pkg::SHORT_LAST;
    req_o.size         = size_d;
    req_o.hlen         = hlen_d;
    req_o.pcount       = pcnt_d;
    req_o.port         = port_d;
    req_o.trap         = trap_d;
    req_o.trap_present = ext_d[1:0] != 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      size_q <= '0;
      port_q <= '0;
      ext_q  <= '0;
      hlen_q <= rfhp_pkg::FIXED_HDR;
      trap_q <= '0;
      pcnt_q <= '0;
    end else if (accept_i) begin
      if (last_i) begin
        idx_q  <= '0;
        size_q <= '0;
        port_q <= '0;
        ext_q  <= '0;
        hlen_q <= rfhp_pkg::FIXED_HDR;
        trap_q <= '0;
        pcnt_q <= '0;
      end else begin
        idx_q  <= idx_d;
        size_q <= size_d;
        port_q <= port_d;
        ext_q  <= ext_d;
        hlen_q <= hlen_d;
        trap_q <= trap_d;
        pcnt_q <= pcnt_d;
      end
    end
  end

endmodule

[rtl/rfhp_queue.sv]
// Short request queue between parser front end and result stage.
// Depends on rfhp_pkg for the request type and depth.
module rfhp_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  rfhp_pkg::entry_t wr_data_i,
  output logic             full_o,
  output logic             avail_o,
  input  logic             rd_i,
  output rfhp_pkg::entry_t rd_data_o
);

  rfhp_pkg::entry_t             mem_q [rfhp_pkg::QDEPTH];
  logic [rfhp_pkg::QPTR_W-1:0]  wptr_q, rptr_q;
  logic [rfhp_pkg::QCNT_W-1:0]  cnt_q;
  logic                         do_wr, do_rd;

  assign full_o    = cnt_q == rfhp_pkg::QCNT_W'(rfhp_pkg::QDEPTH);
  assign avail_o   = cnt_q != '0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && avail_o;
  assign rd_data_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      unique case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[rtl/rfhp_back.sv]
// Result stage: frame status evaluation and registered result slot.
// Depends on rfhp_pkg; drains rfhp_queue.
module rfhp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              avail_i,
  input  rfhp_pkg::entry_t  req_i,
  output logic              take_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [7:0]        payload_byte_o,
  output logic              has_byte_o,
  output logic              end_of_frame_o,
  output rfhp_pkg::status_e frame_status_o,
  output logic [15:0]       system_port_o,
  output logic [7:0]        trap_value_o,
  output logic              trap_present_o
);

  logic                       valid_q;
  logic [7:0]                 byte_q;
  logic                       has_q, eof_q, tp_q;
  rfhp_pkg::status_e          status_q, status_d;
  logic [15:0]                port_q;
  logic [7:0]                 trap_q;
  logic [rfhp_pkg::IDX_W-1:0] hlen_ext;

  assign hlen_ext = {{(rfhp_pkg::IDX_W-rfhp_pkg::HLEN_W){1'b0}}, req_i.hlen};

  always_comb begin
    status_d = rfhp_pkg::ST_OK;
    if (req_i.last) begin
      priority if (!req_i.enable)                       status_d = rfhp_pkg::ST_FRAMER_DISABLED;
      else if (req_i.short_frame)                       status_d = rfhp_pkg::ST_TOO_SMALL;
      else if (req_i.size < hlen_ext)                   status_d = rfhp_pkg::ST_TOO_SMALL;
      else if (req_i.size - hlen_ext != req_i.pcount)   status_d = rfhp_pkg::ST_SIZE_MISMATCH;
      else                                              status_d = rfhp_pkg::ST_OK;
    end
  end

  // slot refills in the same cycle it is popped
  assign take_o  = avail_i && (!valid_q || pop_i);
  assign empty_o = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_o) begin
      valid_q <= 1'b1;
    end else if (pop_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      byte_q   <= req_i.pass ? req_i.data : 8'd0;
      has_q    <= req_i.pass;
      eof_q    <= req_i.last;
      status_q <= status_d;
      port_q   <= req_i.port;
      trap_q   <= req_i.trap;
      tp_q     <= req_i.trap_present;
    end
  end

  assign payload_byte_o = byte_q;
  assign has_byte_o     = has_q;
  assign end_of_frame_o = eof_q;
  assign frame_status_o = status_q;
  assign system_port_o  = port_q;
  assign trap_value_o   = trap_q;
  assign trap_present_o = tp_q;

endmodule

[dv/rfhp_checker.sv]
// Scoreboard for the receive fabric header parser: watches the byte, result
// and enable channels, predicts every result and compares it when it is popped.
// Depends on rfhp_pkg for the status codes, header positions and widths.
module rfhp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_last_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_frame_i,
  input  logic [1:0]  frame_status_i,
  input  logic [15:0] system_port_i,
  input  logic [7:0]  trap_value_i,
  input  logic        trap_present_i,
  output int          waiting_o,
  output int          mismatches_o,
  output int          checked_o
);

  localparam int MIN_FRAME_BYTES = 16;

  typedef struct packed {
    logic [7:0]        data;
    logic              has;
    logic              eof;
    rfhp_pkg::status_e st;
    logic [15:0]       port;
    logic [7:0]        trap;
    logic              tp;
  } parse_result_t;

  parse_result_t parse_result_t_q[$];
  parse_result_t want;
  int            mismatch_cnt;
  int            checked_cnt;

  // predicted frame state
  logic                        fr_en;
  logic [rfhp_pkg::IDX_W-1:0]  fr_idx;
  logic [rfhp_pkg::IDX_W-1:0]  fr_size;
  logic [15:0]                 fr_port;
  logic [3:0]                  fr_ext;
  logic [rfhp_pkg::HLEN_W-1:0] fr_hlen;
  logic [7:0]                  fr_trap;
  logic [rfhp_pkg::IDX_W-1:0]  fr_pcnt;

  task automatic clear_frame();
    fr_idx  = '0;
    fr_size = '0;
    fr_port = '0;
    fr_ext  = '0;
    fr_hlen = rfhp_pkg::FIXED_HDR;
    fr_trap = '0;
    fr_pcnt = '0;
  endtask

  // one accepted byte: update frame state, queue the result it causes
  task automatic parse_byte(input logic [7:0] b, input logic fin);
    parse_result_t              r;
    logic [rfhp_pkg::IDX_W-1:0] idx;
    logic [1:0]                 e4;
    logic                       body;
    logic                       fwd;
    rfhp_pkg::status_e          st;
    idx = fr_idx;
    case (idx)
      rfhp_pkg::POS_SIZE_HI: fr_size[13:6] = b;
      rfhp_pkg::POS_SIZE_LO: fr_size[5:0]  = b[7:2];
      rfhp_pkg::POS_PORT_HI: fr_port[15:9] = b[6:0];
      rfhp_pkg::POS_PORT_MD: fr_port[8:1]  = b;
      rfhp_pkg::POS_PORT_LO: fr_port[0]    = b[7];
      rfhp_pkg::POS_SYS_HDR: begin
        fr_ext  = b[7:4];
        fr_hlen = rfhp_pkg::FIXED_HDR + (b[7] ? 6'd3 : 6'd0) + (b[6] ? 6'd5 : 6'd0);
        case (b[5:4])
          2'd1: fr_hlen = fr_hlen + 6'd3;
          2'd2: fr_hlen = fr_hlen + 6'd5;
          2'd3: fr_hlen = fr_hlen + 6'd8;
          default: ;
        endcase
      end
      default: ;
    endcase
    e4 = fr_ext[1:0];
    if ((e4 == 2'd1 && idx == 14'd18) || (e4 == 2'd2 && idx == 14'd20) ||
        (e4 == 2'd3 && idx == 14'd23))
      fr_trap = b;
    // everything past the header minus the CRC allowance is payload
    body = int'(idx) >= int'(fr_hlen) - int'(rfhp_pkg::CRC_KEEP);
    fwd  = body && fr_en;
    if (body && fr_pcnt != rfhp_pkg::IDX_MAX) fr_pcnt = fr_pcnt + 1'b1;
    if (fr_idx != rfhp_pkg::IDX_MAX) fr_idx = fr_idx + 1'b1;
    st = rfhp_pkg::ST_OK;
    if (fin) begin
      if (!fr_en) st = rfhp_pkg::ST_FRAMER_DISABLED;
      else if (int'(fr_idx) < MIN_FRAME_BYTES) st = rfhp_pkg::ST_TOO_SMALL;
      else if (int'(fr_size) < int'(fr_hlen)) st = rfhp_pkg::ST_TOO_SMALL;
      else if (int'(fr_size) - int'(fr_hlen) != int'(fr_pcnt))
        st = rfhp_pkg::ST_SIZE_MISMATCH;
    end
    if (fwd || fin) begin
      r.data = fwd ? b : 8'h00;
      r.has  = fwd;
      r.eof  = fin;
      r.st   = st;
      r.port = fr_port;
      r.trap = fr_trap;
      r.tp   = (fr_ext[1:0] != 2'd0);
      parse_result_t_q.push_back(r);
    end
    if (fin) clear_frame();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_en = 1'b0;
      clear_frame();
      parse_result_t_q.delete();
      mismatch_cnt = 0;
      checked_cnt  = 0;
      waiting_o    <= 0;
      mismatches_o <= 0;
      checked_o    <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (parse_result_t_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result with none predicted: byte %h has %b eof %b st %0d",
                     $time, payload_byte_i, has_byte_i, end_of_frame_i, frame_status_i);
        end else begin
          want = parse_result_t_q.pop_front();
          checked_cnt++;
          if (payload_byte_i !== want.data || has_byte_i !== want.has ||
              end_of_frame_i !== want.eof || frame_status_i !== want.st ||
              system_port_i !== want.port || trap_value_i !== want.trap ||
              trap_present_i !== want.tp) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: exp byte %h has %b eof %b st %0d port %h trap %h tp %b",
                       $time, want.data, want.has, want.eof, want.st, want.port,
                       want.trap, want.tp);
              $display("%0t: got byte %h has %b eof %b st %0d port %h trap %h tp %b",
                       $time, payload_byte_i, has_byte_i, end_of_frame_i,
                       frame_status_i, system_port_i, trap_value_i, trap_present_i);
            end
          end
        end
      end
      if (cfg_we_i) fr_en = cfg_wdata_i;
      if (push_i && !full_i) parse_byte(frame_byte_i, frame_last_i);
      waiting_o    <= parse_result_t_q.size();
      mismatches_o <= mismatch_cnt;
      checked_o    <= checked_cnt;
    end
  end

endmodule

[dv/testbench.sv]
// Top of the parser testbench: clock, reset, frame stimulus, result sink and
// verdict. Depends on rx_fabric_header_parser, rfhp_checker and rfhp_pkg.
module testbench;

  localparam int LIMIT      = 400000;
  localparam int HOLD_LEN   = 300;
  localparam int PHASE_LEN  = 350;

  typedef enum int {FR_GOOD, FR_BAD_SIZE, FR_UNDERSIZE, FR_SHORT, FR_NOISE} frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  logic        cfg_wd;
  logic        push;
  logic        full;
  logic [7:0]  frame_byte_i;
  logic        frame_last_i;
  logic        empty;
  logic        pop;
  logic [7:0]  payload_byte_o;
  logic        has_byte_o;
  logic        end_of_frame_o;
  logic [1:0]  frame_status_o;
  logic [15:0] system_port_o;
  logic [7:0]  trap_value_o;
  logic        trap_present_o;

  int   waiting;
  int   mismatches;
  int   checked;
  int   bytes_sent;
  int   frames_sent;
  int   cycle_cnt;
  logic framer_on;
  logic calm;
  logic hold_go;
  logic hold_on;

  always #2 clk_i = ~clk_i;

  rx_fabric_header_parser u_top (
    .clk_i,
    .rst_ni,
    .framer_enable_we_i   (cfg_we),
    .framer_enable_wdata_i(cfg_wd),
    .push,
    .full,
    .frame_byte_i,
    .frame_last_i,
    .empty,
    .pop,
    .payload_byte_o,
    .has_byte_o,
    .end_of_frame_o,
    .frame_status_o,
    .system_port_o,
    .trap_value_o,
    .trap_present_o
  );

  rfhp_checker u_chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wd),
    .push_i        (push),
    .full_i        (full),
    .frame_byte_i,
    .frame_last_i,
    .empty_i       (empty),
    .pop_i         (pop),
    .payload_byte_i(payload_byte_o),
    .has_byte_i    (has_byte_o),
    .end_of_frame_i(end_of_frame_o),
    .frame_status_i(frame_status_o),
    .system_port_i (system_port_o),
    .trap_value_i  (trap_value_o),
    .trap_present_i(trap_present_o),
    .waiting_o     (waiting),
    .mismatches_o  (mismatches),
    .checked_o     (checked)
  );

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 13);
  endfunction

  // offer one byte request and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    frame_byte_i <= b;
    frame_last_i <= fin;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  // stop sending and wait until every predicted result has been taken
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (waiting != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_enable(input logic on);
    cfg_we    <= 1'b1;
    cfg_wd    <= on;
    framer_on  = on;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // flip_at: byte index before which the enable is toggled, -1 for none
  task automatic send_frame(input frame_kind_e kind, input int pay_len, input int flip_at,
                            input int sys_in);
    logic [7:0]  sys;
    logic [7:0]  b;
    logic [13:0] szf;
    int          hl;
    int          len;
    int          sz;
    sys = (sys_in < 0) ? 8'($urandom) : 8'(sys_in);
    hl  = 18 + (sys[7] ? 3 : 0) + (sys[6] ? 5 : 0);
    case (sys[5:4])
      2'd1: hl += 3;
      2'd2: hl += 5;
      2'd3: hl += 8;
      default: ;
    endcase
    len = hl - 2 + pay_len;
    sz  = hl + pay_len;
    case (kind)
      FR_BAD_SIZE: begin
        if ($urandom_range(0, 3) == 0) sz = $urandom_range(0, 16383);
        else if (pay_len > 0 && $urandom_range(0, 1) == 1)
          sz = hl + $urandom_range(0, pay_len - 1);
        else sz = hl + pay_len + $urandom_range(1, 40);
      end
      FR_UNDERSIZE: sz = $urandom_range(0, hl - 1);
      FR_SHORT:     len = $urandom_range(1, 15);
      FR_NOISE:     len = $urandom_range(1, 40);
      default: ;
    endcase
    szf = 14'(sz);
    for (int i = 0; i < len; i++) begin
      if (i == flip_at) begin
        settle();
        set_enable(!framer_on);
      end
      b = 8'($urandom);
      if (kind != FR_NOISE) begin
        if (i == 0) b = szf[13:6];
        else if (i == 1) b = {szf[5:0], b[1:0]};
        else if (i == 9) b = sys;
      end
      send_byte(b, i == len - 1);
    end
    frames_sent++;
  endtask

  // result sink: random gap per result, plus one long hold-off
  initial begin : result_sink
    int gap;
    pop <= 1'b0;
    gap  = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) gap = draw_gap();
      if (hold_on || gap > 0) begin
        if (!hold_on) gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : sink_hold
    hold_on <= 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    hold_on <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk_i);
    hold_on <= 1'b0;
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still outstanding", cycle_cnt, waiting);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    frame_kind_e kind;
    int          pick;
    int          pay;
    int          flip;
    int          target;
    rst_ni       <= 1'b0;
    push         <= 1'b0;
    frame_byte_i <= 8'h00;
    frame_last_i <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wd       <= 1'b0;
    calm         <= 1'b0;
    hold_go      <= 1'b0;
    framer_on     = 1'b0;
    bytes_sent    = 0;
    frames_sent   = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lone byte with framer off, lone byte with it on, minimal good frame
    send_byte(8'hFF, 1'b1);
    settle();
    set_enable(1'b1);
    send_byte(8'h00, 1'b1);
    send_frame(FR_GOOD, 0, -1, 8'h00);

    // random phases: enable on, off, on with a stalled sink, on again
    for (int ph = 0; ph < 4; ph++) begin
      settle();
      set_enable(ph != 1);
      calm <= (ph == 2);
      if (ph == 2) hold_go <= 1'b1;
      target = bytes_sent + PHASE_LEN;
      while (bytes_sent < target) begin
        pick = $urandom_range(0, 99);
        kind = pick < 60 ? FR_GOOD : pick < 75 ? FR_BAD_SIZE :
               pick < 83 ? FR_UNDERSIZE : pick < 93 ? FR_SHORT : FR_NOISE;
        pay  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(0, 24);
        flip = (ph != 2 && $urandom_range(0, 19) == 0) ? $urandom_range(0, 30) : -1;
        send_frame(kind, pay, flip, -1);
      end
    end
    settle();

    $display("sent %0d frames / %0d bytes, checked %0d results", frames_sent, bytes_sent,
             checked);
    $display("framer on and off, mid-frame enable flips, sink stall with full queue");
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[files.f]
rtl/rfhp_pkg.sv
rtl/rfhp_front.sv
rtl/rfhp_queue.sv
rtl/rfhp_back.sv
rtl/rx_fabric_header_parser.sv
dv/rfhp_checker.sv
dv/testbench.sv
